FILE: sv/hsl_to_rgb_convert_assert.svh
// assertion macros for the hsl to rgb converter
`ifndef HSL_TO_RGB_CONVERT_ASSERT_SVH
`define HSL_TO_RGB_CONVERT_ASSERT_SVH

// property checked at every clock edge outside reset
`define HSL2RGB_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("assertion failed in %m");

// antecedent in one cycle implies consequent in the next
`define HSL2RGB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed in %m");

`endif

FILE: sv/hsl2rgb_pkg.sv
// shared constants, types and helper functions of the hsl to rgb converter
`default_nettype none

package hsl2rgb_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int CH_W       = FRAC_BITS;
    localparam int OUT_W      = 8;
    localparam int NUM_CHAN   = 3;
    localparam int IN_DATA_W  = 3 * CH_W;
    localparam int OUT_DATA_W = NUM_CHAN * OUT_W;
    localparam int TURN_W     = FRAC_BITS + 2;
    localparam int PROD_W     = 2 * CH_W;
    localparam int Q2_W       = 2 * CH_W + 2;
    localparam int QH_W       = Q2_W - FRAC_BITS;

    // pipeline stage indexes
    localparam int ST_PROD    = 0;
    localparam int ST_SUM     = 1;
    localparam int ST_QUOT    = 2;
    localparam int ST_BOUND   = 3;
    localparam int ST_RAMP    = 4;
    localparam int ST_SCALE   = 5;
    localparam int NUM_STAGES = 6;

    // channel lanes
    localparam int CH_RED     = 0;
    localparam int CH_GREEN   = 1;
    localparam int CH_BLUE    = 2;

    typedef logic [CH_W-1:0]   frac_t;
    typedef logic [CH_W-1:0]   dist_t;
    typedef logic [OUT_W-1:0]  chan_t;
    typedef logic [TURN_W-1:0] turn_t;
    typedef logic [TURN_W:0]   wide_turn_t;
    typedef logic [PROD_W-1:0] prod_t;
    typedef logic [Q2_W-1:0]   q2_t;
    typedef logic [QH_W:0]     quo_t;

    typedef struct packed {
        logic [NUM_STAGES-1:0] ld;
    } pipe_ctl_t;

    localparam frac_t FULL       = '1;
    localparam turn_t TURN       = turn_t'(1) << FRAC_BITS;
    localparam turn_t HALF_TURN  = TURN >> 1;
    localparam turn_t TURN_3HALF = TURN + HALF_TURN;
    localparam turn_t TURN2      = TURN << 1;
    localparam turn_t TURN3      = TURN2 + TURN;
    localparam dist_t K_HALF     = dist_t'(1) << (FRAC_BITS - 1);
    localparam chan_t CHAN_MAX   = '1;

    // hue shift per lane: red +1/3, green 0, blue -1/3 (as +2/3)
    localparam turn_t HUE_OFFS [NUM_CHAN] = '{TURN, turn_t'(0), TURN2};

    // distance into the rising or falling sixth, units of 1/(3T);
    // plateau at q maps to a half turn of weight, plateau at p to zero
    function automatic dist_t hue_dist(frac_t h, turn_t offset);
        wide_turn_t sum;
        turn_t      t;
        dist_t      k;
        sum = wide_turn_t'(h) + wide_turn_t'({h, 1'b0}) + wide_turn_t'(offset);
        if (sum >= wide_turn_t'(TURN3)) begin
            sum = sum - wide_turn_t'(TURN3);
        end
        t = turn_t'(sum);
        if (t < HALF_TURN) begin
            k = dist_t'(t);
        end else if (t < TURN_3HALF) begin
            k = K_HALF;
        end else if (t < TURN2) begin
            k = dist_t'(TURN2 - t);
        end else begin
            k = '0;
        end
        return k;
    endfunction

    // floor(v / 257): estimate v*255 >> 16, then one upward correction
    function automatic chan_t scale_chan(frac_t v);
        logic [CH_W+OUT_W-1:0] prod;
        logic [OUT_W:0]        est;
        logic [OUT_W:0]        inc;
        logic [2*OUT_W:0]      back;
        prod = {v, OUT_W'(0)} - (CH_W+OUT_W)'(v);
        est  = (OUT_W+1)'(prod[CH_W+OUT_W-1:CH_W]);
        inc  = est + 1'b1;
        back = {inc, OUT_W'(0)} + (2*OUT_W+1)'(inc);
        if (back <= {1'b0, v}) begin
            est = inc;
        end
        return (est > (OUT_W+1)'(CHAN_MAX)) ? CHAN_MAX : chan_t'(est);
    endfunction

endpackage

`default_nettype wire

FILE: sv/hsl_to_rgb_convert.sv
// hsl to rgb pixel converter, top level with pipeline flow control
// each beat passes the product, sum, quotient, bound, ramp and scale stages in order
// throughput: one pixel per cycle while the output is not stalled; each stage advances on its own, so bubbles close up
// a stalled output holds its beat while upstream stages keep filling
// reset: synchronous active-low aresetn clears the stage valid bits only
`default_nettype none

`include "hsl_to_rgb_convert_assert.svh"

module hsl_to_rgb_convert import hsl2rgb_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // input pixel beats
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,   // hue [15:0], saturation [31:16], lightness [47:32]
    // result beats
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_DATA_W-1:0]      m_tdata    // red [7:0], green [15:8], blue [23:16]
);

    // stage valid bits travel alongside the payload
    logic [NUM_STAGES-1:0] valid_reg, valid_next;
    pipe_ctl_t             ctl;
    logic                  in_beat, out_beat;

    frac_t hue, saturation, lightness;
    frac_t bound_p, bound_d;
    dist_t ramp_pos [NUM_CHAN];
    chan_t chan [NUM_CHAN];

    assign hue        = s_tdata[CH_W-1:0];
    assign saturation = s_tdata[2*CH_W-1:CH_W];
    assign lightness  = s_tdata[3*CH_W-1:2*CH_W];

    // a stage loads when it is empty or its contents move on this cycle
    always_comb begin
        ctl.ld[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || m_tready;
        for (int i = NUM_STAGES - 2; i >= 0; i--) begin
            ctl.ld[i] = !valid_reg[i] || ctl.ld[i+1];
        end
    end

    always_comb begin
        valid_next[0] = ctl.ld[0] ? s_tvalid : valid_reg[0];
        for (int i = 1; i < NUM_STAGES; i++) begin
            valid_next[i] = ctl.ld[i] ? valid_reg[i-1] : valid_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_tready = ctl.ld[0];
    assign m_tvalid = valid_reg[NUM_STAGES-1];
    assign in_beat  = s_tvalid && s_tready;
    assign out_beat = m_tvalid && m_tready;

    // chroma bounds: product, sum, divide by full scale, clamp
    hsl2rgb_chroma u_chroma (
        .aclk       (aclk),
        .ctl        (ctl),
        .saturation (saturation),
        .lightness  (lightness),
        .bound_p    (bound_p),
        .bound_d    (bound_d)
    );

    // hue ramp positions, delayed to line up with the chroma bounds
    hsl2rgb_hue u_hue (
        .aclk     (aclk),
        .ctl      (ctl),
        .hue      (hue),
        .ramp_pos (ramp_pos)
    );

    // one ramp and scaling lane per color channel
    for (genvar c = 0; c < NUM_CHAN; c++) begin : g_lane
        hsl2rgb_ramp u_ramp (
            .aclk     (aclk),
            .ctl      (ctl),
            .bound_p  (bound_p),
            .bound_d  (bound_d),
            .ramp_pos (ramp_pos[c]),
            .chan     (chan[c])
        );
    end

    assign m_tdata = {chan[CH_BLUE], chan[CH_GREEN], chan[CH_RED]};

    // a full pipeline with a stalled output cannot take a new beat
    `HSL2RGB_ASSERT(a_full_blocks_input, ((&valid_reg) && !m_tready) |-> !s_tready)
    // an accepted beat always lands in the first stage
    `HSL2RGB_ASSERT_NEXT(a_beat_enters, in_beat, valid_reg[0])
    // beats in flight change only by what enters and leaves
    `HSL2RGB_ASSERT(a_beat_count, $past(aresetn) |-> ($countones(valid_reg) + int'($past(out_beat)) == $countones($past(valid_reg)) + int'($past(in_beat))))
    // lower bound plus span is q, which never passes full scale
    `HSL2RGB_ASSERT(a_chroma_range, valid_reg[ST_BOUND] |-> (({1'b0, bound_p} + {1'b0, bound_d}) <= {1'b0, FULL}))
    // ramp positions never pass the plateau weight
    `HSL2RGB_ASSERT(a_pos_range, valid_reg[ST_BOUND] |-> ((ramp_pos[CH_RED] <= K_HALF) && (ramp_pos[CH_GREEN] <= K_HALF) && (ramp_pos[CH_BLUE] <= K_HALF)))

endmodule

`default_nettype wire

FILE: sv/hsl2rgb_chroma.sv
// chroma bounds p and q from saturation and lightness, four stages
`default_nettype none

module hsl2rgb_chroma import hsl2rgb_pkg::*; (
    input  wire logic      aclk,
    input  wire pipe_ctl_t ctl,
    input  wire frac_t     saturation,
    input  wire frac_t     lightness,
    output frac_t          bound_p,
    output frac_t          bound_d
);

    frac_t l1_reg, s1_reg, l2_reg, l3_reg;
    prod_t ls1_reg;
    q2_t   q2_reg, q2_next;
    quo_t  qq_reg, qq_next;
    frac_t p_reg, p_next, d_reg, d_next;

    // q scaled by M*M, one of two forms depending on lightness half
    always_comb begin
        q2_t lsum;
        q2_t lo;
        q2_t hi;
        lsum = q2_t'(l1_reg) + q2_t'(s1_reg);
        lo   = (q2_t'(l1_reg) << FRAC_BITS) - q2_t'(l1_reg) + q2_t'(ls1_reg);
        hi   = (lsum << FRAC_BITS) - lsum - q2_t'(ls1_reg);
        if (q2_t'({l1_reg, 1'b0}) < q2_t'(FULL)) begin
            q2_next = lo;
        end else begin
            q2_next = hi;
        end
    end

    // divide by 2^F - 1: fold high part into low part twice, one correction
    always_comb begin
        logic [QH_W:0]       c;
        logic [FRAC_BITS:0]  e;
        logic [QH_W-FRAC_BITS:0] c1;
        c       = (QH_W+1)'(q2_reg[Q2_W-1:FRAC_BITS]) + (QH_W+1)'(q2_reg[FRAC_BITS-1:0]);
        c1      = c[QH_W:FRAC_BITS];
        e       = (FRAC_BITS+1)'(c[FRAC_BITS-1:0]) + (FRAC_BITS+1)'(c1);
        qq_next = quo_t'(q2_reg[Q2_W-1:FRAC_BITS]) + quo_t'(c1)
                + quo_t'(e >= (FRAC_BITS+1)'(FULL));
    end

    // clamp q, then p = 2l - q and the span d = q - p
    always_comb begin
        logic [CH_W:0] two_l;
        quo_t          qb;
        frac_t         q;
        two_l = {l3_reg, 1'b0};
        qb    = qq_reg;
        if (qb > quo_t'(FULL)) begin
            qb = quo_t'(FULL);
        end
        if (qb > quo_t'(two_l)) begin
            qb = quo_t'(two_l);
        end
        q      = frac_t'(qb);
        p_next = frac_t'(two_l - (CH_W+1)'(q));
        d_next = q - p_next;
    end

    always_ff @(posedge aclk) begin
        if (ctl.ld[ST_PROD]) begin
            l1_reg  <= lightness;
            s1_reg  <= saturation;
            ls1_reg <= prod_t'(lightness) * prod_t'(saturation);
        end
        if (ctl.ld[ST_SUM]) begin
            l2_reg <= l1_reg;
            q2_reg <= q2_next;
        end
        if (ctl.ld[ST_QUOT]) begin
            l3_reg <= l2_reg;
            qq_reg <= qq_next;
        end
        if (ctl.ld[ST_BOUND]) begin
            p_reg <= p_next;
            d_reg <= d_next;
        end
    end

    assign bound_p = p_reg;
    assign bound_d = d_reg;

endmodule

`default_nettype wire

FILE: sv/hsl2rgb_hue.sv
// shifted hue positions of the three channels, carried alongside the chroma stages
`default_nettype none

module hsl2rgb_hue import hsl2rgb_pkg::*; (
    input  wire logic      aclk,
    input  wire pipe_ctl_t ctl,
    input  wire frac_t     hue,
    output dist_t          ramp_pos [NUM_CHAN]
);

    dist_t k_reg [NUM_CHAN][ST_BOUND+1];

    always_ff @(posedge aclk) begin
        for (int c = 0; c < NUM_CHAN; c++) begin
            if (ctl.ld[ST_PROD]) begin
                k_reg[c][ST_PROD] <= hue_dist(hue, HUE_OFFS[c]);
            end
            for (int st = ST_PROD + 1; st <= ST_BOUND; st++) begin
                if (ctl.ld[st]) begin
                    k_reg[c][st] <= k_reg[c][st-1];
                end
            end
        end
    end

    always_comb begin
        for (int c = 0; c < NUM_CHAN; c++) begin
            ramp_pos[c] = k_reg[c][ST_BOUND];
        end
    end

endmodule

`default_nettype wire

FILE: sv/hsl2rgb_ramp.sv
// one channel: ramp value p + d*k, then scaling to 8 bits
`default_nettype none

module hsl2rgb_ramp import hsl2rgb_pkg::*; (
    input  wire logic      aclk,
    input  wire pipe_ctl_t ctl,
    input  wire frac_t     bound_p,
    input  wire frac_t     bound_d,
    input  wire dist_t     ramp_pos,
    output chan_t          chan
);

    frac_t v_reg, v_next;
    chan_t chan_reg;

    // d*2k/T never exceeds d, so p plus it stays within q
    always_comb begin
        prod_t         prod;
        logic [CH_W:0] sum;
        prod   = prod_t'(bound_d) * prod_t'(ramp_pos);
        sum    = (CH_W+1)'(bound_p)
               + (CH_W+1)'(prod[CH_W+FRAC_BITS-2:FRAC_BITS-1]);
        v_next = frac_t'(sum);
    end

    always_ff @(posedge aclk) begin
        if (ctl.ld[ST_RAMP]) begin
            v_reg <= v_next;
        end
        if (ctl.ld[ST_SCALE]) begin
            chan_reg <= scale_chan(v_reg);
        end
    end

    assign chan = chan_reg;

endmodule

`default_nettype wire
